@@ design/vle_pkg.sv @@
// ---------------------------------------------------------------------------
// vle_pkg : shared types and constants for the vector level-1 engine
// Mode codes, the job record passed from front to back, widths.
// ---------------------------------------------------------------------------
package vle_pkg;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned MODE_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_DOT   = 4'd0,
    MODE_NORM  = 4'd1,
    MODE_MAXAB = 4'd2,
    MODE_AXPY  = 4'd3,
    MODE_WSUM  = 4'd4,
    MODE_ASUM  = 4'd5,
    MODE_ADIFF = 4'd6,
    MODE_SCALE = 4'd7,
    MODE_ACONS = 4'd8,
    MODE_COPY  = 4'd9
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_B = 2'd2;

  // one classified item travelling from front to back
  typedef struct packed {
    mode_t             mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic              last;
  } job_t;

endpackage

@@ design/vle_front.sv @@
// ---------------------------------------------------------------------------
// vle_front : input stage and job queue
// Accepts beats, drops undefined modes, queues jobs for the back end.
// ---------------------------------------------------------------------------
module vle_front import vle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,
  input  logic        in_tlast,
  input  mode_t       mode,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job
);

  localparam int unsigned DEPTH = 2;

  job_t        q_r [DEPTH];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        push, pop, defined;

  assign defined   = (mode <= MODE_COPY);
  assign in_tready = (cnt_r != 2'(DEPTH));
  assign push      = in_tvalid && in_tready && defined;
  assign pop       = job_valid && job_ready;
  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{mode: mode, x: in_tdata[31:0], y: in_tdata[63:32],
                     z: in_tdata[95:64], last: in_tlast};
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ design/vle_sqrt.sv @@
// ---------------------------------------------------------------------------
// vle_sqrt : iterative integer square root
// One root bit per cycle from each radicand bit pair; 32 steps for 64 bits,
// done pulses the cycle after the last step.
// ---------------------------------------------------------------------------
module vle_sqrt import vle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rem_r;
  logic [31:0] res_r;
  logic [63:0] src_r;
  logic [5:0]  step_r;
  logic        busy_r;
  logic [65:0] trial;
  logic [65:0] cur;

  assign cur   = {rem_r, src_r[63:62]};
  assign trial = cur - {32'd0, res_r, 2'b01};
  assign root  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rem_r  <= '0;
        res_r  <= '0;
        src_r  <= radicand;
        step_r <= '0;
      end else if (busy_r) begin
        src_r <= {src_r[61:0], 2'b00};
        if (!trial[65]) begin
          rem_r <= trial[63:0];
          res_r <= {res_r[30:0], 1'b1};
        end else begin
          rem_r <= cur[63:0];
          res_r <= {res_r[30:0], 1'b0};
        end
        step_r <= step_r + 6'd1;
        if (step_r == 6'd31) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/vle_back.sv @@
// ---------------------------------------------------------------------------
// vle_back : execution unit
// Multiply stage, combine/accumulate stage, square root, output register.
// ---------------------------------------------------------------------------
module vle_back import vle_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ACC_WIDTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  job_t               job,
  input  logic signed [31:0] scale_a,
  input  logic signed [31:0] scale_b,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [31:0]        out_tdata,
  output logic [1:0]         out_tuser
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_ROOT, S_OUT} st_t;

  localparam logic signed [65:0] P_MAX = {3'b000, {63{1'b1}}};
  localparam logic signed [65:0] P_MIN = {3'b111, {63{1'b0}}};
  localparam logic signed [65:0] A_MAX = 66'sd0 + ((66'sd1 <<< (ACC_WIDTH-1)) - 66'sd1);
  localparam logic signed [65:0] A_MIN = -A_MAX - 66'sd1;
  localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
  localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

  st_t                st_r;
  job_t               j_r;
  logic signed [65:0] p1_r, p2_r;
  logic signed [ACC_WIDTH-1:0] acc_r;
  logic [32:0]        rmax_r;
  logic               ovf_r;
  logic [31:0]        val_r;
  logic [1:0]         usr_r;
  logic               sq_start, sq_done;
  logic [31:0]        sq_root;

  logic signed [32:0] opx, opm;
  logic signed [65:0] m1, m2, f1, f2, r, sacc, s66;
  logic [32:0]        ax;

  function automatic logic signed [65:0] sat64(input logic signed [65:0] v);
    if (v > P_MAX) return P_MAX;
    if (v < P_MIN) return P_MIN;
    return v;
  endfunction

  function automatic logic signed [65:0] fl(input logic signed [65:0] v);
    return v >>> FRAC_BITS;
  endfunction

  assign job_ready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata  = val_r;
  assign out_tuser  = usr_r;

  // multiplier operands
  always_comb begin
    opx = 33'(j_r.x);
    case (j_r.mode)
      MODE_ASUM:  opx = 33'(j_r.x) + 33'(j_r.y);
      MODE_ADIFF: opx = 33'(j_r.x) - 33'(j_r.y);
      default:    opx = 33'(j_r.x);
    endcase
    opm = 33'(scale_a);
    if (j_r.mode == MODE_DOT)  opm = 33'(j_r.y);
    if (j_r.mode == MODE_NORM) opm = 33'(j_r.x);
    m1 = 66'(opx) * 66'(opm);
    m2 = 66'(j_r.y) * 66'(scale_b);
    ax = j_r.x[31] ? 33'(-34'(j_r.x)) : 33'(j_r.x);
  end

  always_comb begin
    f1 = fl(p1_r);
    f2 = fl(p2_r);
    case (j_r.mode)
      MODE_AXPY:  r = f1 + 66'(j_r.y);
      MODE_WSUM:  r = f1 + f2;
      MODE_ASUM,
      MODE_ADIFF: r = f1 + 66'(j_r.z);
      MODE_SCALE: r = f1;
      MODE_ACONS: r = 66'(scale_a) + 66'(j_r.x);
      default:    r = 66'(j_r.x);
    endcase
    r    = sat64(r);
    s66  = sat64(66'(acc_r) + p1_r);
    sacc = s66;
    if (sacc > A_MAX) sacc = A_MAX;
    if (sacc < A_MIN) sacc = A_MIN;
  end

  // root of the sum that includes the last element
  assign sq_start = (st_r == S_ADD) && (j_r.mode == MODE_NORM) && j_r.last;

  vle_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start),
    .radicand(sacc[65] ? 64'd0 : sacc[63:0]),
    .done(sq_done), .root(sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      acc_r  <= '0;
      rmax_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: if (job_valid) begin
          j_r  <= job;
          st_r <= S_MUL;
        end
        S_MUL: begin
          p1_r <= sat64(m1);
          p2_r <= sat64(m2);
          st_r <= S_ADD;
        end
        S_ADD: begin
          if (j_r.mode == MODE_DOT || j_r.mode == MODE_NORM) begin
            acc_r <= ACC_WIDTH'(sacc);
            if (s66 > A_MAX || s66 < A_MIN || s66 == P_MAX || s66 == P_MIN) ovf_r <= 1'b1;
            if (!j_r.last) st_r <= S_IDLE;
            else if (j_r.mode == MODE_NORM) st_r <= S_ROOT;
            else begin
              if (fl(sacc) > S32_MAX) val_r <= 32'h7fffffff;
              else if (fl(sacc) < S32_MIN) val_r <= 32'h80000000;
              else val_r <= 32'(fl(sacc));
              usr_r <= {ovf_r || fl(sacc) > S32_MAX || fl(sacc) < S32_MIN
                        || s66 > A_MAX || s66 < A_MIN || s66 == P_MAX || s66 == P_MIN,
                        1'b1};
              acc_r <= '0; ovf_r <= 1'b0; rmax_r <= '0;
              st_r  <= S_OUT;
            end
          end else if (j_r.mode == MODE_MAXAB) begin
            if (!j_r.last) begin
              if (ax > rmax_r) rmax_r <= ax;
              st_r <= S_IDLE;
            end else begin
              if (ax > rmax_r) begin
                val_r <= (ax[32] || ax[31]) ? 32'h7fffffff : ax[31:0];
                usr_r <= {ovf_r || ax[32] || ax[31], 1'b1};
              end else begin
                val_r <= (rmax_r[32] || rmax_r[31]) ? 32'h7fffffff : rmax_r[31:0];
                usr_r <= {ovf_r || rmax_r[32] || rmax_r[31], 1'b1};
              end
              acc_r <= '0; ovf_r <= 1'b0; rmax_r <= '0;
              st_r  <= S_OUT;
            end
          end else begin
            if (r > S32_MAX) val_r <= 32'h7fffffff;
            else if (r < S32_MIN) val_r <= 32'h80000000;
            else val_r <= 32'(r);
            usr_r <= {(r > S32_MAX) || (r < S32_MIN), j_r.last};
            st_r  <= S_OUT;
          end
        end
        S_ROOT: if (sq_done) begin
          val_r <= sq_root[31] ? 32'h7fffffff : sq_root;
          usr_r <= {ovf_r || sq_root[31], 1'b1};
          acc_r <= '0; ovf_r <= 1'b0; rmax_r <= '0;
          st_r  <= S_OUT;
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/vector_level1_engine_top.sv @@
// ---------------------------------------------------------------------------
// vector_level1_engine_top : streaming BLAS level-1 vector unit, Q16.16
// Element-wise and reduction modes on x, y, z element streams.
// ---------------------------------------------------------------------------
// channel | dir | tdata                          | tuser / tlast
// in_     | in  | x_elem, y_elem, z_elem         | tlast = last_elem
// out_    | out | value                          | tuser = is_last, saturated
// cfg_    | in  | wdata (mode, scale_a, scale_b) | -
//
// Each beat takes the back end's load, multiply and combine states; beats
// that yield a result then take the result state, a norm after the sqrt unit.
// A two-entry job queue lets the front accept while the back works.
// Reset is synchronous, active low; it clears control state and config.
// Output stall holds the result register; the queue fills and in_tready drops.
module vector_level1_engine_top import vle_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned ACC_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // x_elem, y_elem, z_elem
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value
  output logic [1:0]  out_tuser,  // is_last, saturated
  input  logic        cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_wdata
);

  mode_t              mode_r;
  logic signed [31:0] scale_a_r, scale_b_r;
  logic               job_valid, job_ready;
  job_t               job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_DOT;
      scale_a_r <= 32'sd65536;
      scale_b_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:    mode_r    <= mode_t'(cfg_wdata[MODE_W-1:0]);
        REG_SCALE_A: scale_a_r <= cfg_wdata;
        REG_SCALE_B: scale_b_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  vle_front u_front (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast), .mode(mode_r),
    .job_valid(job_valid), .job_ready(job_ready), .job(job)
  );

  vle_back #(.FRAC_BITS(FRAC_BITS), .ACC_WIDTH(ACC_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
    .job(job), .scale_a(scale_a_r), .scale_b(scale_b_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

endmodule

@@ design/vle_checker.sv @@
// ---------------------------------------------------------------------------
// vle_checker : port-level checks for the vector engine
// Stream stability, result spacing and reset behavior.
// ---------------------------------------------------------------------------
module vle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat dropped under stall");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("back-to-back result beats");

endmodule

bind vector_level1_engine_top vle_checker u_vle_checker (
  .clk(clk), .rst_n(rst_n), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser)
);
